FILE: sv/uart_tx_fifo_serializer_unit_defines.svh
// ----------------------------------------------------------------------------
// uart tx fifo serializer assertion macros
// concurrent assertion wrappers, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef UART_TX_FIFO_SERIALIZER_UNIT_DEFINES_SVH
`define UART_TX_FIFO_SERIALIZER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define UTFS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("utfs assertion failed");
// expression must never be true out of reset
`define UTFS_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("utfs forbidden condition seen");
`else
`define UTFS_ASSERT(lbl, clk, rst_n, prop)
`define UTFS_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

FILE: sv/utfs_pkg.sv
// ----------------------------------------------------------------------------
// utfs_pkg
// shared types and constants of the uart tx fifo serializer
// ----------------------------------------------------------------------------
`default_nettype none

package utfs_pkg;

  localparam int unsigned DATA_W    = 8;
  localparam int unsigned TPB_W     = 8;
  localparam int unsigned BIT_IDX_W = 4;

  localparam logic [TPB_W-1:0]     TPB_RESET     = 8'd4;
  localparam logic [BIT_IDX_W-1:0] BIT_START     = 4'd1;
  localparam logic [BIT_IDX_W-1:0] BIT_DATA_FST  = 4'd2;
  localparam logic [BIT_IDX_W-1:0] BIT_DATA_LAST = 4'd9;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef struct packed {
    logic              push;
    logic              pop;
    logic [DATA_W-1:0] wdata;
  } fifo_req_t;

  typedef struct packed {
    logic              nonempty;
    logic [DATA_W-1:0] head;
  } fifo_status_t;

  typedef struct packed {
    logic line;
    logic busy;
  } ser_status_t;

endpackage

`default_nettype wire

FILE: sv/utfs_fifo.sv
// ----------------------------------------------------------------------------
// utfs_fifo
// byte queue with registered head read and write bypass
// ----------------------------------------------------------------------------
`default_nettype none

module utfs_fifo #(
  parameter int unsigned FIFO_DEPTH = 64,
  parameter int unsigned LVL_W      = $clog2(FIFO_DEPTH + 1)
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire utfs_pkg::fifo_req_t     req_i,
  output      utfs_pkg::fifo_status_t  status_o,
  output      logic [LVL_W-1:0]        level_o,
  output      logic                    dropped_o
);

  localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

  logic [utfs_pkg::DATA_W-1:0] mem [FIFO_DEPTH];
  logic [utfs_pkg::DATA_W-1:0] head_q;
  logic [PTR_W-1:0]            wp_q, wp_d, rp_q, rp_d;
  logic [LVL_W-1:0]            level_q, level_d;
  logic                        full, push_ok;

  assign full    = (level_q == LVL_W'(FIFO_DEPTH));
  assign push_ok = req_i.push && !full;

  always_comb begin
    wp_d    = wp_q;
    rp_d    = rp_q;
    level_d = level_q;
    if (push_ok) begin
      wp_d = (wp_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wp_q + 1'b1;
    end
    if (req_i.pop) begin
      rp_d = (rp_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rp_q + 1'b1;
    end
    if (push_ok && !req_i.pop) begin
      level_d = level_q + 1'b1;
    end else if (!push_ok && req_i.pop) begin
      level_d = level_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      level_q <= '0;
    end else begin
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      level_q <= level_d;
    end
  end

  // head always mirrors the entry at the read pointer
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem[wp_q] <= req_i.wdata;
    end
    if (push_ok && (wp_q == rp_d)) begin
      head_q <= req_i.wdata;
    end else begin
      head_q <= mem[rp_d];
    end
  end

  assign status_o.nonempty = (level_q != '0);
  assign status_o.head     = head_q;
  assign level_o           = level_d;
  assign dropped_o         = req_i.push && full;

endmodule

`default_nettype wire

FILE: sv/utfs_serial.sv
// ----------------------------------------------------------------------------
// utfs_serial
// tick divider and 8n1 frame shifter
// ----------------------------------------------------------------------------
`default_nettype none

module utfs_serial (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          tick_i,
  input  wire logic [utfs_pkg::TPB_W-1:0]    tpb_i,
  input  wire utfs_pkg::fifo_status_t        fifo_st_i,
  output      logic                          load_o,
  output      utfs_pkg::ser_status_t         st_o
);

  logic [utfs_pkg::DATA_W-1:0]    shift_q, shift_d, shift_mid;
  logic [utfs_pkg::BIT_IDX_W-1:0] bi_q, bi_d, bi_inc;
  logic [utfs_pkg::TPB_W-1:0]     div_q, div_d, div_base, div_inc;
  logic                           busy_q, busy_d, busy_mid;
  logic                           line_q, line_d;
  logic                           fire;

  assign load_o = tick_i && !busy_q && fifo_st_i.nonempty;

  always_comb begin
    shift_mid = load_o ? fifo_st_i.head : shift_q;
    busy_mid  = load_o ? 1'b1 : busy_q;
    div_base  = load_o ? '0 : div_q;
    div_inc   = div_base + 1'b1;
    fire      = (div_inc >= tpb_i) || (div_inc == '0);
    bi_inc    = bi_q + 1'b1;

    shift_d = shift_q;
    bi_d    = bi_q;
    div_d   = div_q;
    busy_d  = busy_q;
    line_d  = line_q;
    if (tick_i) begin
      shift_d = shift_mid;
      busy_d  = busy_mid;
      div_d   = fire ? '0 : div_inc;
      if (fire && busy_mid) begin
        if (bi_inc == utfs_pkg::BIT_START) begin
          line_d = 1'b0;
          bi_d   = bi_inc;
        end else if (bi_inc inside {[utfs_pkg::BIT_DATA_FST:utfs_pkg::BIT_DATA_LAST]}) begin
          line_d  = shift_mid[0];
          shift_d = shift_mid >> 1;
          bi_d    = bi_inc;
        end else begin
          // stop bit
          line_d = 1'b1;
          bi_d   = '0;
          busy_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= '0;
      bi_q    <= '0;
      div_q   <= '0;
      busy_q  <= 1'b0;
      line_q  <= 1'b1;
    end else begin
      shift_q <= shift_d;
      bi_q    <= bi_d;
      div_q   <= div_d;
      busy_q  <= busy_d;
      line_q  <= line_d;
    end
  end

  assign st_o.line = line_d;
  assign st_o.busy = busy_d;

endmodule

`default_nettype wire

FILE: sv/uart_tx_fifo_serializer_unit.sv
// ----------------------------------------------------------------------------
// uart_tx_fifo_serializer_unit
// 8n1 uart transmitter fed from a byte fifo, one push or tick per request
// ----------------------------------------------------------------------------
//  channel  | valid       | stall        | payload
//  ---------+-------------+--------------+------------------------------------
//  in       | in_valid_i  | in_stall_o   | op_i, byte_in_i
//  out      | out_valid_o | out_stall_i  | tx_line_o, sending_o,
//           |             |              | push_dropped_o, fifo_level_o
//  cfg      | cfg_we_i    | -            | cfg_wdata_i (ticks per bit)
//
//  one request per clock sustained while the result is not stalled; a request
//  passes the input register, then the result register
//  the fifo head is a registered memory read kept current by write bypass
//  reset leaves the serializer line high, fifo empty, ticks per bit at 4
//  a stalled result holds while the input register still takes a request
// ----------------------------------------------------------------------------
`default_nettype none

`include "uart_tx_fifo_serializer_unit_defines.svh"

module uart_tx_fifo_serializer_unit #(
  parameter  int unsigned FIFO_DEPTH = 64,
  localparam int unsigned LVL_W      = $clog2(FIFO_DEPTH + 1)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [utfs_pkg::TPB_W-1:0]  cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output      logic                        in_stall_o,
  input  wire logic                        op_i,
  input  wire logic [utfs_pkg::DATA_W-1:0] byte_in_i,
  output      logic                        out_valid_o,
  input  wire logic                        out_stall_i,
  output      logic                        tx_line_o,
  output      logic                        sending_o,
  output      logic                        push_dropped_o,
  output      logic [LVL_W-1:0]            fifo_level_o
);

  logic [utfs_pkg::TPB_W-1:0]  tpb_q;
  logic                        s1_valid_q, s1_valid_d;
  utfs_pkg::op_e               s1_op_q;
  logic [utfs_pkg::DATA_W-1:0] s1_byte_q;
  logic                        out_valid_q, out_valid_d;
  logic                        out_line_q, out_busy_q, out_drop_q;
  logic [LVL_W-1:0]            out_level_q;
  logic                        advance, accept_in, tick, load;
  logic                        fifo_dropped;
  logic [LVL_W-1:0]            fifo_level;
  utfs_pkg::fifo_req_t         fifo_req;
  utfs_pkg::fifo_status_t      fifo_st;
  utfs_pkg::ser_status_t       ser_st;

  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign accept_in  = in_valid_i && !in_stall_o;
  assign tick       = advance && (s1_op_q == utfs_pkg::OP_TICK);

  assign fifo_req.push  = advance && (s1_op_q == utfs_pkg::OP_PUSH);
  assign fifo_req.pop   = load;
  assign fifo_req.wdata = s1_byte_q;

  utfs_fifo #(
    .FIFO_DEPTH (FIFO_DEPTH),
    .LVL_W      (LVL_W)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (fifo_req),
    .status_o  (fifo_st),
    .level_o   (fifo_level),
    .dropped_o (fifo_dropped)
  );

  utfs_serial u_serial (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tick_i    (tick),
    .tpb_i     (tpb_q),
    .fifo_st_i (fifo_st),
    .load_o    (load),
    .st_o      (ser_st)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept_in) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpb_q       <= utfs_pkg::TPB_RESET;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tpb_q <= cfg_wdata_i;
      end
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      s1_op_q   <= utfs_pkg::op_e'(op_i);
      s1_byte_q <= byte_in_i;
    end
    if (advance) begin
      out_line_q  <= ser_st.line;
      out_busy_q  <= ser_st.busy;
      out_drop_q  <= fifo_dropped;
      out_level_q <= fifo_level;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign tx_line_o      = out_line_q;
  assign sending_o      = out_busy_q;
  assign push_dropped_o = out_drop_q;
  assign fifo_level_o   = out_level_q;

  `UTFS_ASSERT(a_drop_when_full, clk_i, rst_ni,
               (out_valid_q && out_drop_q) |-> (out_level_q == LVL_W'(FIFO_DEPTH)))
  `UTFS_ASSERT(a_load_goes_busy, clk_i, rst_ni,
               (advance && load) |=> (out_valid_q && out_busy_q))
  `UTFS_ASSERT(a_out_drains, clk_i, rst_ni,
               (out_valid_q && !out_stall_i && !s1_valid_q) |=> !out_valid_q)
  `UTFS_ASSERT_NEVER(a_drop_on_tick, clk_i, rst_ni, tick && fifo_dropped)

endmodule

`default_nettype wire
